@@ src/lts_pkg.sv @@
// shared constants, codes and memory port types for the topological sort block
package lts_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int ID_W      = 64;
  localparam int ORD_W     = $clog2(MAX_NODES);
  localparam int NCNT_W    = $clog2(MAX_NODES + 1);
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
  localparam int DEG_W     = ECNT_W;
  localparam int EDGE_W    = 2 * ORD_W;

  localparam logic [1:0] OP_NODE   = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CYCLE    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ORD_W-1:0]  waddr;
    logic [ID_W-1:0]   wdata;
    logic [ORD_W-1:0]  raddr;
  } nid_req_t;

  typedef struct packed {
    logic               we;
    logic [EADDR_W-1:0] waddr;
    logic [EDGE_W-1:0]  wdata;
    logic [EADDR_W-1:0] raddr;
  } edg_req_t;

  typedef struct packed {
    logic              we;
    logic [ORD_W-1:0]  waddr;
    logic [DEG_W-1:0]  wdata;
    logic [ORD_W-1:0]  raddr;
  } deg_req_t;

  typedef struct packed {
    logic              we;
    logic [ORD_W-1:0]  waddr;
    logic [ORD_W-1:0]  wdata;
    logic [ORD_W-1:0]  raddr;
  } ord_req_t;

  typedef struct packed {
    logic              idle;
    logic [NCNT_W-1:0] node_total;
  } core_sts_t;

endpackage

@@ src/lts_if.sv @@
// handshake channels for input transactions and results
interface lts_in_if
  import lts_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [1:0]      operation;
  logic [ID_W-1:0] node_id;
  logic [ID_W-1:0] edge_before_id;
  logic [ID_W-1:0] edge_after_id;
  modport source (output valid, operation, node_id, edge_before_id, edge_after_id,
                  input ready);
  modport sink (input valid, operation, node_id, edge_before_id, edge_after_id,
                output ready);
endinterface

interface lts_out_if
  import lts_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ORD_W-1:0] node_ordinal;
  logic [1:0]       status;
  logic             last;
  modport source (output valid, node_ordinal, status, last, input ready);
  modport sink (input valid, node_ordinal, status, last, output ready);
endinterface

@@ src/lts_ram.sv @@
// generic simple dual-port ram with registered read
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/lts_core.sv @@
// sequencer: loads, edge resolution, kahn selection passes and emission
module lts_core
  import lts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  lts_in_if.sink              in_ch,
  lts_out_if.source           out_ch,
  output nid_req_t            nid_req,
  input  logic [ID_W-1:0]     nid_rdata,
  output edg_req_t            edg_req,
  input  logic [EDGE_W-1:0]   edg_rdata,
  output deg_req_t            deg_req,
  input  logic [DEG_W-1:0]    deg_rdata,
  output ord_req_t            ord_req,
  input  logic [ORD_W-1:0]    ord_rdata,
  output core_sts_t           sts
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LSRCH = 4'd1;
  localparam logic [3:0] S_LFIN  = 4'd2;
  localparam logic [3:0] S_LINC  = 4'd3;
  localparam logic [3:0] S_PSCAN = 4'd4;
  localparam logic [3:0] S_PFIN  = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_ECHK  = 4'd7;
  localparam logic [3:0] S_EDEC  = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OLD   = 4'd10;
  localparam logic [3:0] S_OHOLD = 4'd11;
  localparam logic [3:0] S_CLR   = 4'd12;

  logic [3:0]          state_r, state_nxt;
  logic [NCNT_W-1:0]   ntot_r, ntot_nxt;
  logic [ECNT_W-1:0]   etot_r, etot_nxt;
  logic [1:0]          err_r, err_nxt;
  logic [MAX_NODES-1:0] dvld_r, dvld_nxt;
  logic [MAX_NODES-1:0] emit_r, emit_nxt;
  logic [NCNT_W-1:0]   k_r, k_nxt;
  logic                ev_r, ev_nxt;
  logic [ORD_W-1:0]    evi_r, evi_nxt;
  logic [ID_W-1:0]     bid_r, bid_nxt, aid_r, aid_nxt;
  logic                bf_r, bf_nxt, af_r, af_nxt;
  logic [ORD_W-1:0]    bo_r, bo_nxt, ao_r, ao_nxt;
  logic                pf_r, pf_nxt;
  logic [ORD_W-1:0]    pick_r, pick_nxt;
  logic [ID_W-1:0]     pmin_r, pmin_nxt;
  logic [NCNT_W-1:0]   done_r, done_nxt;
  logic [ECNT_W-1:0]   ek_r, ek_nxt;
  logic                ov_r, ov_nxt;
  logic [ORD_W-1:0]    oord_r, oord_nxt;
  logic [1:0]          ost_r, ost_nxt;
  logic                olast_r, olast_nxt;
  logic [DEG_W-1:0]    deg_cur;
  logic                acc;

  function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] code);
    first_err = (cur == ST_OK) ? code : cur;
  endfunction

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.node_ordinal = oord_r;
  assign out_ch.status = ost_r;
  assign out_ch.last = olast_r;
  assign sts.idle = (state_r == S_IDLE);
  assign sts.node_total = ntot_r;

  always_comb begin
    state_nxt = state_r;
    ntot_nxt = ntot_r;
    etot_nxt = etot_r;
    err_nxt = err_r;
    dvld_nxt = dvld_r;
    emit_nxt = emit_r;
    k_nxt = k_r;
    ev_nxt = 1'b0;
    evi_nxt = evi_r;
    bid_nxt = bid_r;
    aid_nxt = aid_r;
    bf_nxt = bf_r;
    af_nxt = af_r;
    bo_nxt = bo_r;
    ao_nxt = ao_r;
    pf_nxt = pf_r;
    pick_nxt = pick_r;
    pmin_nxt = pmin_r;
    done_nxt = done_r;
    ek_nxt = ek_r;
    ov_nxt = ov_r;
    oord_nxt = oord_r;
    ost_nxt = ost_r;
    olast_nxt = olast_r;
    nid_req = '0;
    edg_req = '0;
    deg_req = '0;
    ord_req = '0;
    deg_cur = dvld_r[evi_r] ? deg_rdata : '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_ch.operation)
            OP_NODE: begin
              if (ntot_r == NCNT_W'(MAX_NODES)) begin
                err_nxt = first_err(err_r, ST_OVERFLOW);
              end else begin
                nid_req.we = 1'b1;
                nid_req.waddr = ntot_r[ORD_W-1:0];
                nid_req.wdata = in_ch.node_id;
                ntot_nxt = ntot_r + 1'b1;
              end
            end
            OP_EDGE: begin
              if (etot_r == ECNT_W'(MAX_EDGES)) begin
                err_nxt = first_err(err_r, ST_OVERFLOW);
              end else begin
                bid_nxt = in_ch.edge_before_id;
                aid_nxt = in_ch.edge_after_id;
                bf_nxt = 1'b0;
                af_nxt = 1'b0;
                k_nxt = '0;
                state_nxt = S_LSRCH;
              end
            end
            OP_RUN: begin
              if (err_r != ST_OK) begin
                ov_nxt = 1'b1;
                oord_nxt = '0;
                ost_nxt = err_r;
                olast_nxt = 1'b1;
                state_nxt = S_OHOLD;
              end else if (ntot_r == '0) begin
                state_nxt = S_CLR;
              end else begin
                done_nxt = '0;
                k_nxt = '0;
                pf_nxt = 1'b0;
                state_nxt = S_PSCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LSRCH: begin
        // issue one read per cycle, compare the entry read in the cycle before
        nid_req.raddr = k_r[ORD_W-1:0];
        if (k_r < ntot_r) begin
          ev_nxt = 1'b1;
          evi_nxt = k_r[ORD_W-1:0];
          k_nxt = k_r + 1'b1;
        end
        if (ev_r) begin
          if (!bf_r && nid_rdata == bid_r) begin
            bf_nxt = 1'b1;
            bo_nxt = evi_r;
          end
          if (!af_r && nid_rdata == aid_r) begin
            af_nxt = 1'b1;
            ao_nxt = evi_r;
          end
        end else if (k_r >= ntot_r) begin
          state_nxt = S_LFIN;
        end
      end
      S_LFIN: begin
        if (!bf_r || !af_r || bo_r == ao_r) begin
          err_nxt = first_err(err_r, ST_INVALID);
          state_nxt = S_IDLE;
        end else begin
          edg_req.we = 1'b1;
          edg_req.waddr = etot_r[EADDR_W-1:0];
          edg_req.wdata = {bo_r, ao_r};
          etot_nxt = etot_r + 1'b1;
          deg_req.raddr = ao_r;
          evi_nxt = ao_r;
          state_nxt = S_LINC;
        end
      end
      S_LINC: begin
        deg_req.we = 1'b1;
        deg_req.waddr = evi_r;
        deg_req.wdata = deg_cur + 1'b1;
        dvld_nxt[evi_r] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PSCAN: begin
        nid_req.raddr = k_r[ORD_W-1:0];
        deg_req.raddr = k_r[ORD_W-1:0];
        if (k_r < ntot_r) begin
          ev_nxt = 1'b1;
          evi_nxt = k_r[ORD_W-1:0];
          k_nxt = k_r + 1'b1;
        end
        if (ev_r) begin
          if (!emit_r[evi_r] && deg_cur == '0 && (!pf_r || nid_rdata < pmin_r)) begin
            pf_nxt = 1'b1;
            pick_nxt = evi_r;
            pmin_nxt = nid_rdata;
          end
        end else if (k_r >= ntot_r) begin
          state_nxt = S_PFIN;
        end
      end
      S_PFIN: begin
        if (!pf_r) begin
          ov_nxt = 1'b1;
          oord_nxt = '0;
          ost_nxt = ST_CYCLE;
          olast_nxt = 1'b1;
          state_nxt = S_OHOLD;
        end else begin
          emit_nxt[pick_r] = 1'b1;
          ord_req.we = 1'b1;
          ord_req.waddr = done_r[ORD_W-1:0];
          ord_req.wdata = pick_r;
          ek_nxt = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        if (ek_r < etot_r) begin
          edg_req.raddr = ek_r[EADDR_W-1:0];
          state_nxt = S_ECHK;
        end else if (done_r + 1'b1 == ntot_r) begin
          k_nxt = '0;
          state_nxt = S_ORD;
        end else begin
          done_nxt = done_r + 1'b1;
          k_nxt = '0;
          pf_nxt = 1'b0;
          state_nxt = S_PSCAN;
        end
      end
      S_ECHK: begin
        if (edg_rdata[EDGE_W-1:ORD_W] == pick_r) begin
          deg_req.raddr = edg_rdata[ORD_W-1:0];
          evi_nxt = edg_rdata[ORD_W-1:0];
          state_nxt = S_EDEC;
        end else begin
          ek_nxt = ek_r + 1'b1;
          state_nxt = S_ERD;
        end
      end
      S_EDEC: begin
        if (deg_cur != '0) begin
          deg_req.we = 1'b1;
          deg_req.waddr = evi_r;
          deg_req.wdata = deg_cur - 1'b1;
        end
        ek_nxt = ek_r + 1'b1;
        state_nxt = S_ERD;
      end
      S_ORD: begin
        ord_req.raddr = k_r[ORD_W-1:0];
        state_nxt = S_OLD;
      end
      S_OLD: begin
        ov_nxt = 1'b1;
        oord_nxt = ord_rdata;
        ost_nxt = ST_OK;
        olast_nxt = (k_r + 1'b1 == ntot_r);
        state_nxt = S_OHOLD;
      end
      S_OHOLD: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = S_CLR;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_ORD;
          end
        end
      end
      S_CLR: begin
        ntot_nxt = '0;
        etot_nxt = '0;
        err_nxt = ST_OK;
        dvld_nxt = '0;
        emit_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ntot_r <= '0;
      etot_r <= '0;
      err_r <= ST_OK;
      dvld_r <= '0;
      emit_r <= '0;
      ev_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ntot_r <= ntot_nxt;
      etot_r <= etot_nxt;
      err_r <= err_nxt;
      dvld_r <= dvld_nxt;
      emit_r <= emit_nxt;
      ev_r <= ev_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    evi_r <= evi_nxt;
    bid_r <= bid_nxt;
    aid_r <= aid_nxt;
    bf_r <= bf_nxt;
    af_r <= af_nxt;
    bo_r <= bo_nxt;
    ao_r <= ao_nxt;
    pf_r <= pf_nxt;
    pick_r <= pick_nxt;
    pmin_r <= pmin_nxt;
    done_r <= done_nxt;
    ek_r <= ek_nxt;
    oord_r <= oord_nxt;
    ost_r <= ost_nxt;
    olast_r <= olast_nxt;
  end
endmodule

@@ src/lexicographic_topological_sort_top.sv @@
// top level: node, edge, in-degree and order memories around the sequencer
// a node load writes the id table; an edge load searches the id table for both ids,
// then records the edge and bumps the in-degree; a run repeats per node a scan for the
// smallest ready id and an in-degree update per edge, then emits the results as the sink
// takes them; items are taken one at a time; after a run the node and edge totals, error code,
// degree-valid and emitted bits are cleared; synchronous active-low reset clears control state; memories are not swept
module lexicographic_topological_sort_top
  import lts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch
);
  nid_req_t            nid_req;
  edg_req_t            edg_req;
  deg_req_t            deg_req;
  ord_req_t            ord_req;
  logic [ID_W-1:0]     nid_rdata;
  logic [EDGE_W-1:0]   edg_rdata;
  logic [DEG_W-1:0]    deg_rdata;
  logic [ORD_W-1:0]    ord_rdata;
  core_sts_t           sts;

  lts_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_nid_ram (
    .clk(clk), .we(nid_req.we), .waddr(nid_req.waddr), .wdata(nid_req.wdata),
    .raddr(nid_req.raddr), .rdata(nid_rdata)
  );

  lts_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edg_ram (
    .clk(clk), .we(edg_req.we), .waddr(edg_req.waddr), .wdata(edg_req.wdata),
    .raddr(edg_req.raddr), .rdata(edg_rdata)
  );

  lts_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk(clk), .we(deg_req.we), .waddr(deg_req.waddr), .wdata(deg_req.wdata),
    .raddr(deg_req.raddr), .rdata(deg_rdata)
  );

  lts_ram #(.WIDTH(ORD_W), .DEPTH(MAX_NODES)) u_ord_ram (
    .clk(clk), .we(ord_req.we), .waddr(ord_req.waddr), .wdata(ord_req.wdata),
    .raddr(ord_req.raddr), .rdata(ord_rdata)
  );

  lts_core u_core (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .nid_req(nid_req), .nid_rdata(nid_rdata),
    .edg_req(edg_req), .edg_rdata(edg_rdata),
    .deg_req(deg_req), .deg_rdata(deg_rdata),
    .ord_req(ord_req), .ord_rdata(ord_rdata),
    .sts(sts)
  );

  // no result is pending while new transactions are taken
  a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("input ready with result pending");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !sts.idle) else $error("result shown while idle");

  // the final result of a run leaves the block cleared
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> ##1 (sts.node_total == '0))
    else $error("state not cleared after run");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.last && out_ch.node_ordinal == '0))
    else $error("error result not alone");
endmodule

@@ sim/lts_checker.sv @@
// transaction monitor, order predictor and result comparator for the topological sort block
`timescale 1ns / 100ps
module lts_checker
  import lts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lts_in_if    in_ch,
  lts_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [ORD_W-1:0] node_ordinal;
    logic [1:0]       status;
    logic             last;
  } sorted_t;

  sorted_t         sorted_q[$];
  logic [ID_W-1:0] id_tbl[MAX_NODES];
  int              node_cnt;
  int              dep_before[MAX_EDGES];
  int              dep_after[MAX_EDGES];
  int              dep_cnt;
  int              deg_tbl[MAX_NODES];
  logic [1:0]      err_code;

  function automatic int lookup_ordinal(logic [ID_W-1:0] id);
    for (int k = 0; k < node_cnt; k++) begin
      if (id_tbl[k] == id) return k;
    end
    return -1;
  endfunction

  task automatic clear_graph();
    node_cnt = 0;
    dep_cnt  = 0;
    err_code = ST_OK;
    for (int k = 0; k < MAX_NODES; k++) deg_tbl[k] = 0;
  endtask

  task automatic note_error(logic [1:0] code);
    if (err_code == ST_OK) err_code = code;
  endtask

  task automatic sort_graph();
    bit      placed[MAX_NODES];
    int      order[MAX_NODES];
    int      pick;
    bit      looped;
    sorted_t res;
    looped = 0;
    for (int k = 0; k < MAX_NODES; k++) placed[k] = 0;
    for (int d = 0; d < node_cnt && !looped; d++) begin
      pick = -1;
      for (int k = 0; k < node_cnt; k++) begin
        if (!placed[k] && deg_tbl[k] == 0 && (pick < 0 || id_tbl[k] < id_tbl[pick])) pick = k;
      end
      if (pick < 0) begin
        looped = 1;
      end else begin
        placed[pick] = 1;
        order[d] = pick;
        for (int e = 0; e < dep_cnt; e++) begin
          if (dep_before[e] == pick && deg_tbl[dep_after[e]] != 0)
            deg_tbl[dep_after[e]]--;
        end
      end
    end
    if (looped) begin
      res = '{node_ordinal: '0, status: ST_CYCLE, last: 1'b1};
      sorted_q = {sorted_q, res};
    end else begin
      for (int d = 0; d < node_cnt; d++) begin
        res = '{node_ordinal: order[d][ORD_W-1:0], status: ST_OK, last: (d == node_cnt - 1)};
        sorted_q = {sorted_q, res};
      end
    end
  endtask

  task automatic apply_transaction(logic [1:0] op, logic [ID_W-1:0] nid,
                                   logic [ID_W-1:0] bid, logic [ID_W-1:0] aid);
    int      b;
    int      a;
    sorted_t res;
    case (op)
      OP_NODE: begin
        if (node_cnt >= MAX_NODES) begin
          note_error(ST_OVERFLOW);
        end else begin
          id_tbl[node_cnt] = nid;
          node_cnt++;
        end
      end
      OP_EDGE: begin
        if (dep_cnt >= MAX_EDGES) begin
          note_error(ST_OVERFLOW);
        end else begin
          b = lookup_ordinal(bid);
          a = lookup_ordinal(aid);
          if (b < 0 || a < 0 || a == b) begin
            note_error(ST_INVALID);
          end else begin
            dep_before[dep_cnt] = b;
            dep_after[dep_cnt]  = a;
            dep_cnt++;
            deg_tbl[a]++;
          end
        end
      end
      OP_RUN: begin
        if (err_code != ST_OK) begin
          res = '{node_ordinal: '0, status: err_code, last: 1'b1};
          sorted_q = {sorted_q, res};
        end else begin
          sort_graph();
        end
        clear_graph();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    sorted_t got;
    sorted_t want;
    if (!rst_n) begin
      clear_graph();
      sorted_q.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{node_ordinal: out_ch.node_ordinal, status: out_ch.status, last: out_ch.last};
        if (sorted_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ord=%0d st=%0d last=%0b",
                   $time, got.node_ordinal, got.status, got.last);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (got.node_ordinal !== want.node_ordinal) begin
            $display("%0t: node_ordinal expected %0d actual %0d",
                     $time, want.node_ordinal, got.node_ordinal);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        apply_transaction(in_ch.operation, in_ch.node_id, in_ch.edge_before_id,
                          in_ch.edge_after_id);
    end
    pending = sorted_q.size();
  end

endmodule

@@ sim/lexicographic_topological_sort_top_test.sv @@
// stimulus, sink flow control and verdict for the topological sort block
`timescale 1ns / 100ps
module lexicographic_topological_sort_top_test;
  import lts_pkg::*;

  logic clk;
  logic rst_n;
  logic quiet;
  logic hold_req;
  int   fail_count;
  int   pending;
  int   sent;

  lts_in_if  in_ch();
  lts_out_if out_ch();

  lexicographic_topological_sort_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lts_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  // holds one transaction until accepted; may keep valid high for a follow-on item
  task automatic send_item(logic [1:0] op, logic [ID_W-1:0] nid,
                           logic [ID_W-1:0] bid, logic [ID_W-1:0] aid);
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.node_id        <= nid;
    in_ch.edge_before_id <= bid;
    in_ch.edge_after_id  <= aid;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic load_node(logic [ID_W-1:0] nid);
    send_item(OP_NODE, nid, rand_id(), rand_id());
  endtask

  task automatic load_edge(logic [ID_W-1:0] bid, logic [ID_W-1:0] aid);
    send_item(OP_EDGE, rand_id(), bid, aid);
  endtask

  task automatic start_run();
    send_item(OP_RUN, rand_id(), rand_id(), rand_id());
  endtask

  // mostly acyclic graphs with random ids; some back edges, unknown ids and stray codes
  task automatic random_graph(int n, bit noisy);
    logic [ID_W-1:0] ids[MAX_NODES];
    int              ne;
    int              i;
    int              j;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 2))
        0:       ids[k] = rand_id();
        1:       ids[k] = 64'($urandom_range(0, 7));
        default: ids[k] = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 28'h0, 4'($urandom)};
      endcase
      load_node(ids[k]);
    end
    ne = (n > 1) ? $urandom_range(0, 2 * n) : 0;
    for (int e = 0; e < ne; e++) begin
      i = $urandom_range(0, n - 2);
      j = $urandom_range(i + 1, n - 1);
      if (noisy && $urandom_range(0, 9) == 0)
        load_edge(ids[j], ids[i]);
      else if (noisy && $urandom_range(0, 19) == 0)
        load_edge(ids[i], rand_id());
      else if (noisy && $urandom_range(0, 19) == 0)
        send_item(OP_UNUSED, rand_id(), rand_id(), rand_id());
      else
        load_edge(ids[i], ids[j]);
    end
    start_run();
  endtask

  // sink side: random stalls, one long hold-off on request, none near the end
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        out_ch.ready <= 1'b1;
        wait (!hold_req);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int wait_cycles;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_NODE;
    in_ch.node_id        = '0;
    in_ch.edge_before_id = '0;
    in_ch.edge_after_id  = '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    rst_n    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extreme ids, duplicate ids resolve to the first ordinal
    load_node('1);
    load_node('0);
    load_node(64'd5);
    load_node(64'd5);
    load_edge('1, '0);
    load_edge(64'd5, '1);
    hold_req <= 1'b1;
    start_run();
    // sender keeps offering while the sink is held off
    load_node(64'h8000_0000_0000_0000);
    load_node(64'h7FFF_FFFF_FFFF_FFFF);
    hold_req <= 1'b0;
    start_run();
    // self edge
    load_node(64'd7);
    load_edge(64'd7, 64'd7);
    start_run();
    // edge to a node not yet loaded, then a later error is not kept
    load_node(64'd1);
    load_edge(64'd1, 64'd9);
    load_node(64'd9);
    load_edge(64'd9, 64'd9);
    start_run();
    // cycle
    load_node(64'd3);
    load_node(64'd4);
    load_edge(64'd3, 64'd4);
    load_edge(64'd4, 64'd3);
    start_run();
    // empty run and unused code
    start_run();
    send_item(OP_UNUSED, '1, '1, '1);

    // node capacity overflow
    for (int k = 0; k < MAX_NODES + 1; k++) load_node(rand_id());
    start_run();
    // edge capacity overflow on a small graph
    load_node(64'd10);
    load_node(64'd20);
    for (int e = 0; e < MAX_EDGES + 1; e++) load_edge(64'd10, 64'd20);
    start_run();

    while (sent < 355) random_graph($urandom_range(1, 10), $urandom_range(0, 2) == 0);
    quiet = 1'b1;
    repeat (2) random_graph($urandom_range(2, 8), 1'b0);
    in_ch.valid <= 1'b0;

    repeat (2) @(posedge clk);
    wait (pending == 0);
    wait_cycles = 0;
    while (wait_cycles < 500) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
